FILE: src/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants of the LSB embed/extract block.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

	// message store geometry
	localparam int MSG_DEPTH = 128;
	localparam int ADDR_W    = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
	localparam int CNT_W     = $clog2(MSG_DEPTH + 1);

	// frame layout
	localparam int LEN_BITS = 32;
	// frame bit index: covers 32 + 8 * 255 decoded bytes and the embed terminator
	localparam int BP_W     = 12;

	// request queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// configuration
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CARRIER = 2'd2;
	localparam logic [7:0]           MAXLEN_RST  = 8'd100;

	// request type codes on the input channel
	localparam logic [1:0] REQ_START  = 2'd0;
	localparam logic [1:0] REQ_LOAD   = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_TOO_SMALL = 2'd2,
		ST_BAD_LEN  = 2'd3
	} status_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  byte_val;
		logic [15:0] sample;
	} item_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [7:0]  byte_val;
		logic        bvalid;
		logic        blast;
		status_t     status;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

FILE: src/lse_front.sv
// ----------------------------------------------------------------------------
// lse_front
// Input side: takes requests and classifies them into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_front (
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [1:0]      req_type,
	input  wire logic [7:0]      msg_byte,
	input  wire logic [15:0]     carrier_sample,
	input  wire lse_pkg::q_stat_t q_stat,
	output logic                 push,
	output lse_pkg::item_t       item
);

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		item.byte_val = msg_byte;
		item.sample   = carrier_sample;
		case (req_type)
			lse_pkg::REQ_START:  item.op = lse_pkg::OP_START;
			lse_pkg::REQ_LOAD:   item.op = lse_pkg::OP_LOAD;
			lse_pkg::REQ_SAMPLE: item.op = lse_pkg::OP_SAMPLE;
			default:             item.op = lse_pkg::OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/lse_queue.sv
// ----------------------------------------------------------------------------
// lse_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lse_pkg::item_t   push_item,
	input  wire logic             pop,
	output lse_pkg::q_stat_t      q_stat,
	output lse_pkg::item_t        head
);

	lse_pkg::item_t                 ent_q [lse_pkg::Q_DEPTH];
	logic [lse_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [lse_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [lse_pkg::Q_CNT_W-1:0]    cnt_q;

	assign q_stat.full  = (cnt_q == lse_pkg::Q_CNT_W'(lse_pkg::Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lse_pkg::Q_PTR_W'(lse_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lse_pkg::Q_PTR_W'(lse_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/lse_back.sv
// ----------------------------------------------------------------------------
// lse_back
// Execution side: frame state, message store, LSB embed and extract, result.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lse_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [lse_pkg::CFG_DW-1:0]    cfg_wdata,
	input  wire lse_pkg::q_stat_t              q_stat,
	input  wire lse_pkg::item_t                head,
	output logic                               pop,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output lse_pkg::res_t                      res
);

	localparam int BP_W = lse_pkg::BP_W;

	// configuration
	logic        mode_q;
	logic [7:0]  max_len_q;
	logic [31:0] carrier_q;

	// frame state
	logic [lse_pkg::CNT_W-1:0] count_q, count_d;
	logic [BP_W-1:0]           bp_q, bp_d;
	logic [31:0]               len_q, len_d;
	logic [7:0]                bsh_q, bsh_d;
	lse_pkg::status_t          err_q, err_d;

	// message store
	logic [7:0]                 mem [lse_pkg::MSG_DEPTH];
	logic [7:0]                 mem_rd_q;
	logic                       mem_we;
	logic [lse_pkg::ADDR_W-1:0] rd_addr;
	logic [BP_W-1:0]            rd_off;

	logic          out_valid_q;
	lse_pkg::res_t res_q, res_d;

	logic            frame_clr;
	logic [BP_W-1:0] cnt_p1, total, cur_off, cur_idx, ext_end, bp_inc, byte_idx;
	logic [31:0]     cnt_word, len_n;
	logic [7:0]      emb_byte;
	logic            emb_bit, lsb;

	assign pop       = !q_stat.empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign frame_clr = cfg_we && (cfg_idx == lse_pkg::CFG_MODE);

	// embed frame length and current embed bit
	assign cnt_p1   = BP_W'(count_q) + BP_W'(1);
	assign total    = BP_W'(lse_pkg::LEN_BITS) + (cnt_p1 << 3);
	assign cur_off  = bp_q - BP_W'(lse_pkg::LEN_BITS);
	assign cur_idx  = cur_off >> 3;
	assign cnt_word = 32'(count_q);
	assign emb_byte = (cur_idx < BP_W'(count_q)) ? mem_rd_q : 8'h00;
	assign emb_bit  = (bp_q < BP_W'(lse_pkg::LEN_BITS)) ?
		cnt_word[5'd31 - bp_q[4:0]] : emb_byte[3'd7 - bp_q[2:0]];

	// extract helpers
	assign lsb      = head.sample[0];
	assign len_n    = {len_q[30:0], lsb};
	assign ext_end  = BP_W'(lse_pkg::LEN_BITS) + (BP_W'(len_q[7:0]) << 3);
	assign bp_inc   = bp_q + BP_W'(1);
	assign byte_idx = (bp_inc - BP_W'(lse_pkg::LEN_BITS)) >> 3;

	always_comb begin
		count_d = count_q;
		bp_d    = bp_q;
		len_d   = len_q;
		bsh_d   = bsh_q;
		err_d   = err_q;
		mem_we  = 1'b0;
		res_d   = '0;

		if (frame_clr) begin
			count_d = '0;
			bp_d    = '0;
			len_d   = '0;
			bsh_d   = '0;
			err_d   = lse_pkg::ST_OK;
		end else if (pop) begin
			case (head.op)
				lse_pkg::OP_START: begin
					count_d = '0;
					bp_d    = '0;
					len_d   = '0;
					bsh_d   = '0;
					err_d   = lse_pkg::ST_OK;
				end
				lse_pkg::OP_LOAD: begin
					if (!mode_q && bp_q == '0 && err_q == lse_pkg::ST_OK) begin
						if (32'(count_q) < 32'(lse_pkg::MSG_DEPTH)) begin
							mem_we  = 1'b1;
							count_d = count_q + 1'b1;
						end else begin
							err_d = lse_pkg::ST_TOO_LONG;
						end
					end
				end
				lse_pkg::OP_SAMPLE: begin
					res_d.sample = head.sample;
					if (err_q == lse_pkg::ST_OK && !mode_q) begin
						// first sample checks length and capacity
						if (bp_q == '0) begin
							if (32'(count_q) > 32'(max_len_q)) begin
								err_d = lse_pkg::ST_TOO_LONG;
							end else if (carrier_q < 32'(total)) begin
								err_d = lse_pkg::ST_TOO_SMALL;
							end
						end
						if (err_d == lse_pkg::ST_OK && bp_q < total) begin
							res_d.sample = {head.sample[15:1], emb_bit};
							bp_d         = bp_inc;
						end
					end else if (err_q == lse_pkg::ST_OK) begin
						if (bp_q < BP_W'(lse_pkg::LEN_BITS)) begin
							len_d = len_n;
							bp_d  = bp_inc;
							if (bp_q == BP_W'(lse_pkg::LEN_BITS - 1) &&
								(len_n == '0 || len_n > 32'(max_len_q))) begin
								err_d = lse_pkg::ST_BAD_LEN;
							end
						end else if (bp_q < ext_end) begin
							bsh_d = {bsh_q[6:0], lsb};
							bp_d  = bp_inc;
							if (bp_q[2:0] == 3'd7) begin
								res_d.byte_val = {bsh_q[6:0], lsb};
								res_d.bvalid   = 1'b1;
								res_d.blast    = (byte_idx == BP_W'(len_q[7:0]));
								bsh_d          = '0;
							end
						end
					end
				end
				default: begin
				end
			endcase
			res_d.status = err_d;
		end
	end

	// prefetch the byte that the next embed step needs
	assign rd_off  = bp_d - BP_W'(lse_pkg::LEN_BITS);
	assign rd_addr = (bp_d >= BP_W'(lse_pkg::LEN_BITS)) ?
		rd_off[lse_pkg::ADDR_W+2:3] : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[lse_pkg::ADDR_W-1:0]] <= head.byte_val;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			max_len_q   <= lse_pkg::MAXLEN_RST;
			carrier_q   <= '0;
			count_q     <= '0;
			bp_q        <= '0;
			len_q       <= '0;
			bsh_q       <= '0;
			err_q       <= lse_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					lse_pkg::CFG_MODE:    mode_q    <= cfg_wdata[0];
					lse_pkg::CFG_MAXLEN:  max_len_q <= cfg_wdata[7:0];
					lse_pkg::CFG_CARRIER: carrier_q <= cfg_wdata[31:0];
					default: begin
					end
				endcase
			end
			count_q <= count_d;
			bp_q    <= bp_d;
			len_q   <= len_d;
			bsh_q   <= bsh_d;
			err_q   <= err_d;
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/lsb_stego_embed_extract.sv
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract: hide and recover a message in carrier sample LSBs
// Result is registered in the back behind the queue; 1 req/clk while out_stall
// is low and the queue is not empty; the queue holds 2 requests.
// Reset clears config (max_length 100), frame state and queue; store undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_embed_extract (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration writes
	input  wire logic                          cfg_we,
	input  wire logic [lse_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [lse_pkg::CFG_DW-1:0]    cfg_wdata,
	// request channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    req_type,
	input  wire logic [7:0]                    msg_byte,
	input  wire logic [15:0]                   carrier_sample,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [15:0]                        out_sample,
	output logic [7:0]                         byte_out,
	output logic                               byte_valid,
	output logic                               byte_last,
	output logic [1:0]                         status
);

	// front classifies each request and drops it into the queue;
	// back pops one request per clock whenever its result register is free
	lse_pkg::item_t   front_item;
	lse_pkg::item_t   head_item;
	lse_pkg::q_stat_t q_stat;
	lse_pkg::res_t    res;
	logic             push;
	logic             pop;

	lse_front u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.msg_byte       (msg_byte),
		.carrier_sample (carrier_sample),
		.q_stat         (q_stat),
		.push           (push),
		.item           (front_item)
	);

	// decouple: the input side keeps taking requests while a result waits, until the queue is full
	lse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.q_stat    (q_stat),
		.head      (head_item)
	);

	// execute: embed length and message bits, or rebuild length and bytes
	lse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.head      (head_item),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res)
	);

	// unpack the result register onto the field ports
	assign out_sample = res.sample;
	assign byte_out   = res.byte_val;
	assign byte_valid = res.bvalid;
	assign byte_last  = res.blast;
	assign status     = res.status;

endmodule

`default_nettype wire

FILE: src/lse_checker.sv
// ----------------------------------------------------------------------------
// lse_checker
// Port-level checks of the LSB embed/extract block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] out_sample,
	input wire logic [7:0]  byte_out,
	input wire logic        byte_valid,
	input wire logic        byte_last,
	input wire logic [1:0]  status
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_sample) &&
			$stable(byte_out) && $stable(status))
		else $error("stalled result changed");

	// the last flag only marks a recovered byte
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_last |-> byte_valid)
		else $error("byte_last without byte_valid");

	// no byte leaves a frame in error
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> status == lse_pkg::ST_OK)
		else $error("byte emitted with frame error");

	// byte field is zero when no byte is recovered
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> byte_out == 8'h00 && !byte_last)
		else $error("byte field set without byte_valid");

endmodule

bind lsb_stego_embed_extract lse_checker u_lse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_sample (out_sample),
	.byte_out   (byte_out),
	.byte_valid (byte_valid),
	.byte_last  (byte_last),
	.status     (status)
);

`default_nettype wire
